@@ hw/rtl/bezier_point_evaluator_macros.svh @@
// Assertion macros for the Bezier point evaluator.
// Used by bezier_point_evaluator.sv; expects clk and rst_n in scope.
`ifndef BEZIER_POINT_EVALUATOR_MACROS_SVH
`define BEZIER_POINT_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bezier_point_evaluator: property failed");
`define BPE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bezier_point_evaluator: forbidden condition seen");
`else
`define BPE_ASSERT(lbl, prop)
`define BPE_NEVER(lbl, cond)
`endif
`endif

@@ hw/rtl/bpe_pkg.sv @@
// Shared types and codes for the Bezier point evaluator.
// No dependencies.
package bpe_pkg;

  localparam int MAX_POINTS_DEF = 32;

  localparam logic [16:0] T_ONE = 17'd65536;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Q12.4 point, x in the low half as in the point stores
  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LEVEL = 4'b0010,
    S_FRD   = 4'b0100,
    S_FCAP  = 4'b1000
  } state_t;

endpackage

@@ hw/rtl/bpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bpe_lerp.sv @@
// Two-lane rounded linear interpolation unit, one registered multiply stage.
// Depends on bpe_pkg.
module bpe_lerp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  bpe_pkg::point_t a,
  input  bpe_pkg::point_t b,
  input  logic [16:0]     t,
  output logic            out_vld,
  output bpe_pkg::point_t res
);

  // a + floor((t*(b-a) + 32768) / 65536) equals the rounded convex combination
  logic signed [16:0] dx, dy;
  logic signed [17:0] ts;
  logic signed [34:0] px_nxt, py_nxt;
  logic signed [34:0] px_r, py_r;
  bpe_pkg::point_t    a_r;
  logic               vld_r;
  logic signed [34:0] sx, sy;
  logic signed [18:0] rx, ry;

  assign dx = 17'({b.x[15], b.x}) - 17'({a.x[15], a.x});
  assign dy = 17'({b.y[15], b.y}) - 17'({a.y[15], a.y});
  assign ts = $signed({1'b0, t});
  assign px_nxt = 35'(dx * ts);
  assign py_nxt = 35'(dy * ts);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    a_r  <= a;
  end

  assign sx = px_r + 35'sd32768;
  assign sy = py_r + 35'sd32768;
  assign rx = 19'({{3{a_r.x[15]}}, a_r.x}) + sx[34:16];
  assign ry = 19'({{3{a_r.y[15]}}, a_r.y}) + sy[34:16];

  assign out_vld = vld_r;
  assign res.x   = rx[15:0];
  assign res.y   = ry[15:0];

endmodule

@@ hw/rtl/bezier_point_evaluator.sv @@
// Bezier point evaluator: de Casteljau reduction over a shared lerp unit.
// Clear and append: result registered in the cycle after the request. Evaluation
// runs one lerp step per cycle, reading the point store on the first level and
// the single-read-port work RAM after it, one level at a time.
// Not ready while an evaluation runs; the next request is taken with the result.
// Synchronous active-low reset empties the point store; RAM contents are not cleared.
`include "bezier_point_evaluator_macros.svh"
module bezier_point_evaluator #(
  parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // point_x[15:0], point_y[31:16], param_t[48:32], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // curve_x[15:0], curve_y[31:16], point_count[37:32], pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

  bpe_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   wr_idx_r, wr_idx_nxt;
  logic            src_work_r, src_work_nxt;
  logic [16:0]     t_r, t_nxt;
  logic            s1_vld_r, s1_vld_nxt;
  logic            s1_first_r, s1_first_nxt;
  bpe_pkg::point_t prev_r;

  logic            out_vld_r, out_vld_nxt;
  bpe_pkg::point_t out_pt_r, out_pt_nxt;
  logic [5:0]      out_cnt_r, out_cnt_nxt;
  logic [1:0]      out_st_r, out_st_nxt;

  logic            in_req;
  logic [1:0]      in_op;
  bpe_pkg::point_t in_pt;
  logic [16:0]     in_t;
  logic            issue;
  logic            st_we;
  bpe_pkg::point_t st_rdata, wk_rdata, cur;
  logic            lerp_vld;
  bpe_pkg::point_t lerp_res;

  assign in_op   = in_tuser;
  assign in_pt.x = in_tdata[15:0];
  assign in_pt.y = in_tdata[31:16];
  assign in_t    = in_tdata[48:32];

  assign in_tready = (state_r == bpe_pkg::S_IDLE) && (!out_vld_r || out_tready);
  assign in_req    = in_tvalid && in_tready;

  assign st_we = in_req && (in_op == bpe_pkg::OP_APPEND) && (count_r < CNT_MAX);
  assign issue = (state_r == bpe_pkg::S_LEVEL) && (idx_r < n_r);
  assign cur   = src_work_r ? wk_rdata : st_rdata;

  bpe_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_pt),
    .raddr (idx_r[AW-1:0]),
    .rdata (st_rdata)
  );

  bpe_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_work (
    .clk   (clk),
    .we    (lerp_vld),
    .waddr (wr_idx_r),
    .wdata (lerp_res),
    .raddr (idx_r[AW-1:0]),
    .rdata (wk_rdata)
  );

  bpe_lerp u_lerp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s1_vld_r && !s1_first_r),
    .a       (prev_r),
    .b       (cur),
    .t       (t_r),
    .out_vld (lerp_vld),
    .res     (lerp_res)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    wr_idx_nxt   = lerp_vld ? wr_idx_r + AW'(1) : wr_idx_r;
    src_work_nxt = src_work_r;
    t_nxt        = t_r;
    s1_vld_nxt   = issue;
    s1_first_nxt = (idx_r == '0);
    out_vld_nxt  = out_vld_r && !out_tready;
    out_pt_nxt   = out_pt_r;
    out_cnt_nxt  = out_cnt_r;
    out_st_nxt   = out_st_r;
    if (issue) begin
      idx_nxt = idx_r + CW'(1);
    end

    unique case (state_r)
      bpe_pkg::S_IDLE: begin
        if (in_req) begin
          out_vld_nxt = 1'b1;
          out_pt_nxt  = '0;
          out_st_nxt  = bpe_pkg::ST_OK;
          case (in_op)
            bpe_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            bpe_pkg::OP_APPEND: begin
              if (count_r < CNT_MAX) begin
                count_nxt = count_r + CW'(1);
              end else begin
                out_st_nxt = bpe_pkg::ST_FULL;
              end
            end
            bpe_pkg::OP_EVAL: begin
              t_nxt = (in_t > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : in_t;
              if (count_r == '0) begin
                out_st_nxt = bpe_pkg::ST_EMPTY;
              end else begin
                // result goes out when the reduction finishes
                out_vld_nxt  = 1'b0;
                n_nxt        = count_r;
                idx_nxt      = '0;
                wr_idx_nxt   = '0;
                src_work_nxt = 1'b0;
                state_nxt    = (count_r == CW'(1)) ? bpe_pkg::S_FRD : bpe_pkg::S_LEVEL;
              end
            end
            default: begin
            end
          endcase
          out_cnt_nxt = 6'(count_nxt);
        end
      end
      bpe_pkg::S_LEVEL: begin
        // level done once all reads issued and the pipe has drained
        if (!issue && !s1_vld_r && !lerp_vld) begin
          n_nxt        = n_r - CW'(1);
          idx_nxt      = '0;
          wr_idx_nxt   = '0;
          src_work_nxt = 1'b1;
          if (n_r == CW'(2)) begin
            state_nxt = bpe_pkg::S_FRD;
          end
        end
      end
      bpe_pkg::S_FRD: begin
        state_nxt = bpe_pkg::S_FCAP;
      end
      bpe_pkg::S_FCAP: begin
        out_vld_nxt = 1'b1;
        out_pt_nxt  = cur;
        out_st_nxt  = bpe_pkg::ST_OK;
        out_cnt_nxt = 6'(count_r);
        state_nxt   = bpe_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bpe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bpe_pkg::S_IDLE;
      count_r   <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    src_work_r <= src_work_nxt;
    t_r        <= t_nxt;
    s1_first_r <= s1_first_nxt;
    out_pt_r   <= out_pt_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_st_r   <= out_st_nxt;
    if (s1_vld_r) begin
      prev_r <= cur;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_pt_r.y, out_pt_r.x};
  assign out_tuser  = out_st_r;

  `BPE_ASSERT(a_idle_pipe_empty, in_tready |-> (!s1_vld_r && !lerp_vld))
  `BPE_NEVER(a_count_bound, count_r > CNT_MAX)
  `BPE_ASSERT(a_eval_busy, (in_req && in_op == bpe_pkg::OP_EVAL && count_r != '0) |=> !in_tready)
  `BPE_NEVER(a_wr_range, lerp_vld && (CW'(wr_idx_r) + CW'(1) >= n_r))

endmodule

@@ tb/sv/bezier_point_evaluator_test.sv @@
// Self-checking testbench for bezier_point_evaluator: a directed table, then
// random clear/append/evaluate sequences, checked against a predictor or the table.
// Depends on bpe_pkg and the bezier_point_evaluator RTL.
`timescale 1ns / 100ps
module bezier_point_evaluator_test;

  localparam int MAX_PTS = bpe_pkg::MAX_POINTS_DEF;
  localparam logic [16:0] T_ONE     = bpe_pkg::T_ONE;
  localparam logic [1:0]  OP_CLEAR  = bpe_pkg::OP_CLEAR;
  localparam logic [1:0]  OP_APPEND = bpe_pkg::OP_APPEND;
  localparam logic [1:0]  OP_EVAL   = bpe_pkg::OP_EVAL;
  localparam logic [1:0]  ST_OK     = bpe_pkg::ST_OK;
  localparam logic [1:0]  ST_EMPTY  = bpe_pkg::ST_EMPTY;
  localparam logic [1:0]  ST_FULL   = bpe_pkg::ST_FULL;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1130;
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]         count;
    logic [1:0]         status;
  } curve_t;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [16:0]        pt;
    int                 reps;
    int                 rand_xy;
    int                 typed;
    curve_t             want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // point_x[15:0], point_y[31:16], param_t[48:32], zero pad
  logic [1:0]  in_tuser = '0;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // curve_x[15:0], curve_y[31:16], point_count[37:32], pad
  logic [1:0]  out_tuser;       // status[1:0]

  // local copy of the control point store
  bpe_pkg::point_t ctrl_pts [MAX_PTS];
  int              ctrl_cnt = 0;

  curve_t    curve_fifo[$];
  int        sent = 0;
  int        fail_count = 0;
  bit        calm = 1'b0;
  stim_row_t dir_rows [23];

  bezier_point_evaluator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // rounded lerp, ties up; arithmetic shift gives the floor
  function automatic logic signed [15:0] blend(logic signed [15:0] a, logic signed [15:0] b,
                                               logic [16:0] t);
    longint s;
    s = longint'(65536 - t) * longint'(a) + longint'(t) * longint'(b) + 64'sd32768;
    return s[31:16];
  endfunction

  function automatic curve_t evaluate_request(logic [1:0] op, logic signed [15:0] px,
                                              logic signed [15:0] py, logic [16:0] pt);
    curve_t          r;
    bpe_pkg::point_t lvl [MAX_PTS];
    logic [16:0]     t;
    r = '0;
    case (op)
      OP_CLEAR: ctrl_cnt = 0;
      OP_APPEND: begin
        if (ctrl_cnt >= MAX_PTS) begin
          r.status = ST_FULL;
        end else begin
          ctrl_pts[ctrl_cnt].x = px;
          ctrl_pts[ctrl_cnt].y = py;
          ctrl_cnt++;
        end
      end
      OP_EVAL: begin
        t = (pt > T_ONE) ? T_ONE : pt;
        if (ctrl_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < ctrl_cnt; i++) lvl[i] = ctrl_pts[i];
          for (int n = ctrl_cnt; n > 1; n--) begin
            for (int i = 0; i < n - 1; i++) begin
              lvl[i].x = blend(lvl[i].x, lvl[i + 1].x, t);
              lvl[i].y = blend(lvl[i].y, lvl[i + 1].y, t);
            end
          end
          r.x = lvl[0].x;
          r.y = lvl[0].y;
        end
      end
      default: ;
    endcase
    r.count = ctrl_cnt[5:0];
    return r;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [16:0] rand_param();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return T_ONE;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  // one request; returns at the edge where it is taken
  task automatic issue(input logic [1:0] op, input logic [15:0] px, input logic [15:0] py,
                       input logic [16:0] pt, input bit typed, input curve_t want);
    curve_t guess;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, pt, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = evaluate_request(op, px, py, pt);
    curve_fifo.insert(curve_fifo.size(), typed ? want : guess);
    sent++;
    calm = (sent > ITEM_TARGET - CALM_TAIL);
  endtask

  // result side stalls
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    curve_t got;
    curve_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x      = out_tdata[15:0];
      got.y      = out_tdata[31:16];
      got.count  = out_tdata[37:32];
      got.status = out_tuser;
      if (curve_fifo.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with nothing pending: x=%0d y=%0d count=%0d status=%0d",
                   $realtime, got.x, got.y, got.count, got.status);
      end else begin
        want = curve_fifo.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.count !== want.count ||
            got.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: exp x=%0d y=%0d n=%0d st=%0d, got x=%0d y=%0d n=%0d st=%0d",
                     $realtime, want.x, want.y, want.count, want.status,
                     got.x, got.y, got.count, got.status);
        end
      end
    end
  end

  initial begin
    int n;
    dir_rows = '{
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd0,     1,  0, 1, '{'0, '0, 6'd0, ST_EMPTY}},
      '{OP_UNUSED, 16'h7fff, 16'h8000, 17'h1ffff, 1,  0, 1, '{'0, '0, 6'd0, ST_OK}},
      '{OP_CLEAR,  16'hffff, 16'hffff, 17'h1ffff, 1,  0, 1, '{'0, '0, 6'd0, ST_OK}},
      '{OP_APPEND, 16'h8000, 16'h7fff, 17'd0,     1,  0, 1, '{'0, '0, 6'd1, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd0,     1,  0, 1, '{16'h8000, 16'h7fff, 6'd1, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, T_ONE,     1,  0, 1, '{16'h8000, 16'h7fff, 6'd1, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'h1ffff, 1,  0, 1, '{16'h8000, 16'h7fff, 6'd1, ST_OK}},
      '{OP_APPEND, 16'h7fff, 16'h8000, 17'd0,     1,  0, 1, '{'0, '0, 6'd2, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd0,     1,  0, 1, '{16'h8000, 16'h7fff, 6'd2, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, T_ONE,     1,  0, 1, '{16'h7fff, 16'h8000, 6'd2, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd65537, 1,  0, 1, '{16'h7fff, 16'h8000, 6'd2, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd32768, 1,  0, 0, '0},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd1,     1,  0, 0, '0},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd65535, 1,  0, 0, '0},
      '{OP_APPEND, 16'hffff, 16'hffff, 17'd0,     1,  0, 0, '0},
      // fill up to the limit with random points
      '{OP_APPEND, 16'h0000, 16'h0000, 17'd0,     29, 1, 0, '0},
      '{OP_APPEND, 16'h1234, 16'h5678, 17'd0,     1,  0, 1, '{'0, '0, 6'd32, ST_FULL}},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd21845, 1,  0, 0, '0},
      '{OP_EVAL,   16'h0000, 16'h0000, T_ONE,     1,  0, 0, '0},
      '{OP_CLEAR,  16'h0000, 16'h0000, 17'd0,     1,  0, 1, '{'0, '0, 6'd0, ST_OK}},
      '{OP_EVAL,   16'h0000, 16'h0000, 17'd40000, 1,  0, 1, '{'0, '0, 6'd0, ST_EMPTY}},
      '{OP_APPEND, 16'h0000, 16'h0000, 17'd0,     1,  0, 0, '0},
      '{OP_UNUSED, 16'h5555, 16'haaaa, 17'h0aaaa, 1,  0, 1, '{'0, '0, 6'd1, ST_OK}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        if (dir_rows[r].rand_xy != 0)
          issue(dir_rows[r].op, rand_coord(), rand_coord(), dir_rows[r].pt, 1'b0, '0);
        else
          issue(dir_rows[r].op, dir_rows[r].px, dir_rows[r].py, dir_rows[r].pt,
                dir_rows[r].typed != 0, dir_rows[r].want);
      end
    end

    // random point sets, mostly small, then one to five evaluations of each
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) != 0)
        issue(OP_CLEAR, 16'($urandom()), 16'($urandom()), 17'($urandom()), 1'b0, '0);
      case ($urandom_range(0, 19))
        0:       n = MAX_PTS + $urandom_range(0, 2);
        1, 2:    n = $urandom_range(9, MAX_PTS - 1);
        default: n = $urandom_range(0, 8);
      endcase
      repeat (n) issue(OP_APPEND, rand_coord(), rand_coord(), 17'($urandom()), 1'b0, '0);
      repeat ($urandom_range(1, 5))
        issue(OP_EVAL, 16'($urandom()), 16'($urandom()), rand_param(), 1'b0, '0);
      if ($urandom_range(0, 5) == 0)
        issue(2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
              17'($urandom_range(0, 131071)), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (curve_fifo.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0 && curve_fifo.size() == 0)
      $display("PASS bezier_point_evaluator");
    else
      $display("FAIL bezier_point_evaluator");
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("FAIL bezier_point_evaluator");
    $finish;
  end

endmodule
